### design/rlsc_pkg.sv
// rlsc_pkg: shared types and constants of the segment clipper
// used by rlsc_ctrl, rlsc_dp and rect_line_segment_clipper; no dependencies

package rlsc_pkg;

    // outcode bit positions
    localparam int unsigned OC_LEFT   = 0;
    localparam int unsigned OC_RIGHT  = 1;
    localparam int unsigned OC_TOP    = 2;
    localparam int unsigned OC_BOTTOM = 3;

    // configuration register indexes
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    // bound on move rounds for a general segment
    localparam int unsigned MAX_ROUNDS = 8;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLAMP,
        OP_MOVE1_START,
        OP_MOVE2_START,
        OP_DIV_STEP,
        OP_MOVE_FINISH
    } t_op;

    // controller to datapath
    typedef struct packed {
        t_op  op;
        logic sel2;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic triv_accept;
        logic triv_reject;
        logic horiz;
        logic vert;
        logic clamp_empty;
        logic c1_nz;
        logic c2_nz;
        logic share;
        logic div_done;
    } t_stat;

endpackage

### design/rlsc_dp.sv
// rlsc_dp: datapath of the segment clipper: edges, outcodes, clamp and the
// shared multiply and restoring long division; depends on rlsc_pkg

module rlsc_dp #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic signed [CW-1:0] i_left,
    input  logic signed [CW-1:0] i_top,
    input  logic        [CW-2:0] i_width,
    input  logic        [CW-2:0] i_height,
    input  logic        [4*CW-1:0] i_seg,
    input  rlsc_pkg::t_cmd       i_cmd,
    output rlsc_pkg::t_stat      o_stat,
    output logic        [4*CW-1:0] o_seg
);
    // internal widths: coordinates at W, products at PW, quotient count
    localparam int W  = CW + 3;
    localparam int PW = 2 * W;
    localparam int DW = W;
    localparam int CNTW = $clog2(PW + 1);

    logic signed [W-1:0] r_x1, r_y1, r_x2, r_y2, r_dx, r_dy;
    logic signed [W-1:0] n_x1, n_y1, n_x2, n_y2;
    logic signed [W-1:0] el, er, et, eb;

    // division state
    logic [PW-1:0]   r_num;
    logic [DW:0]     r_rem;
    logic [DW-1:0]   r_den;
    logic [PW-1:0]   r_q;
    logic [CNTW-1:0] r_cnt;
    logic            r_qneg, r_dz, r_sel2, r_vedge;
    logic signed [W-1:0] r_base, r_edge;

    // rectangle edges
    assign el = W'(i_left);
    assign et = W'(i_top);
    assign er = el + W'($signed({1'b0, i_width}));
    assign eb = et + W'($signed({1'b0, i_height}));

    function automatic logic [3:0] f_oc(input logic signed [W-1:0] x,
                                        input logic signed [W-1:0] y,
                                        input logic signed [W-1:0] l,
                                        input logic signed [W-1:0] r,
                                        input logic signed [W-1:0] t,
                                        input logic signed [W-1:0] b);
        logic [3:0] c;
        c = '0;
        c[rlsc_pkg::OC_LEFT]   = x < l;
        c[rlsc_pkg::OC_RIGHT]  = x > r;
        c[rlsc_pkg::OC_TOP]    = y < t;
        c[rlsc_pkg::OC_BOTTOM] = y > b;
        return c;
    endfunction

    logic [3:0] c1, c2;
    assign c1 = f_oc(r_x1, r_y1, el, er, et, eb);
    assign c2 = f_oc(r_x2, r_y2, el, er, et, eb);

    // move setup for the selected endpoint
    logic signed [W-1:0] mx, my, s_num, s_off, s_den, s_base, s_edge;
    logic s_vedge;
    always_comb begin
        mx = i_cmd.sel2 ? r_x2 : r_x1;
        my = i_cmd.sel2 ? r_y2 : r_y1;
        s_vedge = 1'b1;
        s_edge  = el;
        if (mx < el) begin
            s_edge = el;
        end else if (mx > er) begin
            s_edge = er;
        end else if (my < et) begin
            s_vedge = 1'b0; s_edge = et;
        end else begin
            s_vedge = 1'b0; s_edge = eb;
        end
        if (s_vedge) begin
            s_num = r_dy; s_off = s_edge - mx; s_den = r_dx; s_base = my;
        end else begin
            s_num = r_dx; s_off = s_edge - my; s_den = r_dy; s_base = mx;
        end
    end

    logic [W-1:0]  a_mag, b_mag, d_mag;
    logic [PW-1:0] prod;
    assign a_mag = s_num[W-1] ? W'(-s_num) : W'(s_num);
    assign b_mag = s_off[W-1] ? W'(-s_off) : W'(s_off);
    assign d_mag = s_den[W-1] ? W'(-s_den) : W'(s_den);
    assign prod  = PW'(a_mag) * PW'(b_mag);

    // one restoring division step
    logic [DW:0] sh_rem, sub;
    assign sh_rem = {r_rem[DW-1:0], r_num[PW-1]};
    assign sub    = sh_rem - {1'b0, r_den};

    // finish: truncate the whole sum toward zero
    logic signed [W-1:0] t_val, s_sum, f_val;
    always_comb begin
        t_val = r_qneg ? -W'(r_q) : W'(r_q);
        s_sum = r_base + t_val;
        f_val = s_sum;
        if (r_dz) begin
            f_val = r_base;
        end else if (r_rem != '0) begin
            if (s_sum > 0 && r_qneg)       f_val = s_sum - W'(1);
            else if (s_sum < 0 && !r_qneg) f_val = s_sum + W'(1);
        end
    end

    // clamp of horizontal and vertical segments
    logic clamp_empty;
    always_comb begin
        n_x1 = r_x1; n_y1 = r_y1; n_x2 = r_x2; n_y2 = r_y2;
        clamp_empty = 1'b0;
        if (r_y1 == r_y2) begin
            if (r_x1 < r_x2) begin
                if (r_x1 < el) n_x1 = el;
                if (r_x2 > er) n_x2 = er;
                clamp_empty = n_x1 > n_x2;
            end else begin
                if (r_x2 < el) n_x2 = el;
                if (r_x1 > er) n_x1 = er;
                clamp_empty = n_x1 < n_x2;
            end
        end else begin
            if (r_y1 < r_y2) begin
                if (r_y1 < et) n_y1 = et;
                if (r_y2 > eb) n_y2 = eb;
                clamp_empty = n_y1 > n_y2;
            end else begin
                if (r_y2 < et) n_y2 = et;
                if (r_y1 > eb) n_y1 = eb;
                clamp_empty = n_y1 < n_y2;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rlsc_pkg::OP_LOAD: begin
                r_x1 <= W'($signed(i_seg[CW-1:0]));
                r_y1 <= W'($signed(i_seg[2*CW-1:CW]));
                r_x2 <= W'($signed(i_seg[3*CW-1:2*CW]));
                r_y2 <= W'($signed(i_seg[4*CW-1:3*CW]));
                r_dx <= W'($signed(i_seg[3*CW-1:2*CW])) - W'($signed(i_seg[CW-1:0]));
                r_dy <= W'($signed(i_seg[4*CW-1:3*CW])) - W'($signed(i_seg[2*CW-1:CW]));
            end
            rlsc_pkg::OP_CLAMP: begin
                r_x1 <= n_x1; r_y1 <= n_y1; r_x2 <= n_x2; r_y2 <= n_y2;
            end
            rlsc_pkg::OP_MOVE1_START, rlsc_pkg::OP_MOVE2_START: begin
                r_num   <= prod;
                r_den   <= d_mag;
                r_rem   <= '0;
                r_q     <= '0;
                r_cnt   <= CNTW'(PW);
                r_qneg  <= (s_num[W-1] != s_off[W-1]) != s_den[W-1];
                r_dz    <= s_den == '0;
                r_sel2  <= i_cmd.sel2;
                r_vedge <= s_vedge;
                r_base  <= s_base;
                r_edge  <= s_edge;
            end
            rlsc_pkg::OP_DIV_STEP: begin
                r_num <= {r_num[PW-2:0], 1'b0};
                r_cnt <= r_cnt - CNTW'(1);
                if (!sub[DW]) begin
                    r_rem <= sub;
                    r_q   <= {r_q[PW-2:0], 1'b1};
                end else begin
                    r_rem <= sh_rem;
                    r_q   <= {r_q[PW-2:0], 1'b0};
                end
            end
            rlsc_pkg::OP_MOVE_FINISH: begin
                if (r_sel2) begin
                    if (r_vedge) begin r_x2 <= r_edge; r_y2 <= f_val; end
                    else begin r_y2 <= r_edge; r_x2 <= f_val; end
                end else begin
                    if (r_vedge) begin r_x1 <= r_edge; r_y1 <= f_val; end
                    else begin r_y1 <= r_edge; r_x1 <= f_val; end
                end
            end
            default: begin
            end
        endcase
    end

    // status
    assign o_stat.triv_accept = (c1 | c2) == 4'd0;
    assign o_stat.triv_reject = (c1 & c2) != 4'd0;
    assign o_stat.share       = (c1 & c2) != 4'd0;
    assign o_stat.horiz       = r_y1 == r_y2;
    assign o_stat.vert        = r_x1 == r_x2;
    assign o_stat.clamp_empty = clamp_empty;
    assign o_stat.c1_nz       = c1 != 4'd0;
    assign o_stat.c2_nz       = c2 != 4'd0;
    assign o_stat.div_done    = r_cnt == '0;

    assign o_seg = {r_y2[CW-1:0], r_x2[CW-1:0], r_y1[CW-1:0], r_x1[CW-1:0]};

endmodule

### design/rlsc_ctrl.sv
// rlsc_ctrl: controller state machine of the segment clipper
// depends on rlsc_pkg

module rlsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  rlsc_pkg::t_stat i_stat,
    output rlsc_pkg::t_cmd  o_cmd,
    output logic            o_capture
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLASSIFY, S_CLAMP, S_CLAMP_CHK, S_ROUND, S_M1_DIV,
        S_M1_FIN, S_M1_CHK, S_M2_START, S_M2_DIV, S_M2_FIN, S_M2_CHK
    } t_state;

    t_state     r_state;
    logic [3:0] r_round;
    logic       r_out_valid;

    // registered output holds the last result while the next item runs
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    // command decode
    always_comb begin
        o_cmd.op   = rlsc_pkg::OP_NONE;
        o_cmd.sel2 = 1'b0;
        o_capture  = 1'b0;
        case (r_state)
            S_IDLE:     if (i_in_valid) o_cmd.op = rlsc_pkg::OP_LOAD;
            S_CLAMP:    o_cmd.op = rlsc_pkg::OP_CLAMP;
            S_ROUND: begin
                if (i_stat.c1_nz) o_cmd.op = rlsc_pkg::OP_MOVE1_START;
                else if (i_stat.c2_nz) begin
                    o_cmd.op = rlsc_pkg::OP_MOVE2_START; o_cmd.sel2 = 1'b1;
                end
            end
            S_M2_START: begin
                o_cmd.op = rlsc_pkg::OP_MOVE2_START; o_cmd.sel2 = 1'b1;
            end
            S_M1_DIV, S_M2_DIV:
                if (!i_stat.div_done) o_cmd.op = rlsc_pkg::OP_DIV_STEP;
            S_M1_FIN, S_M2_FIN: o_cmd.op = rlsc_pkg::OP_MOVE_FINISH;
            default: begin
            end
        endcase
        // result capture needs a free output register
        if ((r_state == S_CLASSIFY && i_stat.triv_accept)
            || (r_state == S_CLAMP_CHK && !i_stat.clamp_empty)
            || (r_state == S_ROUND && !i_stat.c1_nz && !i_stat.c2_nz))
            o_capture = !r_out_valid || i_out_ready;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_capture)                     r_out_valid <= 1'b1;
            else if (i_out_ready)              r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_CLASSIFY;
                S_CLASSIFY: begin
                    r_round <= '0;
                    if (i_stat.triv_accept) begin
                        if (o_capture) r_state <= S_IDLE;
                    end else if (i_stat.triv_reject) r_state <= S_IDLE;
                    else if (i_stat.horiz || i_stat.vert) r_state <= S_CLAMP;
                    else r_state <= S_ROUND;
                end
                S_CLAMP: r_state <= S_CLAMP_CHK;
                S_CLAMP_CHK: begin
                    if (i_stat.clamp_empty || o_capture) r_state <= S_IDLE;
                end
                S_ROUND: begin
                    if (!i_stat.c1_nz && !i_stat.c2_nz) begin
                        if (o_capture) r_state <= S_IDLE;
                    end else if (r_round == 4'(rlsc_pkg::MAX_ROUNDS)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_round <= r_round + 4'd1;
                        r_state <= i_stat.c1_nz ? S_M1_DIV : S_M2_DIV;
                    end
                end
                S_M1_DIV: if (i_stat.div_done) r_state <= S_M1_FIN;
                S_M1_FIN: r_state <= S_M1_CHK;
                S_M1_CHK: begin
                    if (i_stat.share) r_state <= S_IDLE;
                    else if (i_stat.c2_nz) r_state <= S_M2_START;
                    else r_state <= S_ROUND;
                end
                S_M2_START: r_state <= S_M2_DIV;
                S_M2_DIV: if (i_stat.div_done) r_state <= S_M2_FIN;
                S_M2_FIN: r_state <= S_M2_CHK;
                S_M2_CHK: r_state <= i_stat.share ? S_IDLE : S_ROUND;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // round bound, loads only when idle, captures only into a free register, and a capture sets the valid
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= 4'(rlsc_pkg::MAX_ROUNDS)) else $error("round count overrun");
    a_capture_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_capture |-> (!r_out_valid || i_out_ready)) else $error("result overwritten");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == rlsc_pkg::OP_LOAD) |-> o_in_ready) else $error("load while busy");
    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_capture |=> o_out_valid) else $error("capture lost");
`endif

endmodule

### design/rect_line_segment_clipper.sv
// rect_line_segment_clipper: top level of the outcode segment clipper
// holds the configuration registers and output register; uses rlsc_pkg,
// rlsc_ctrl and rlsc_dp
//
// usage: one segment beat enters on s_axis (tdata = start_x, start_y, end_x,
// end_y from the lowest bit up). a visible segment leaves as one beat on
// m_axis with the clipped endpoints in the same packing; an invisible segment
// leaves nothing. order is kept.
// configuration: i_cfg_valid/o_cfg_ready with index 0 left, 1 top, 2 width,
// 3 height; write only while no segment is in flight. reset clears all four.
// each endpoint move of a general segment runs the one shared long division,
// which makes one quotient bit per cycle.
// one segment is worked at a time; the input is taken again once the result
// sits in the output register, so a stalled receiver holds the next result
// in the controller until the register frees.
// reset (synchronous, active low) empties the output register.

module rect_line_segment_clipper #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [4*COORD_WIDTH-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // out_start_x, out_start_y, out_end_x, out_end_y from the lowest bit up
    output logic [4*COORD_WIDTH-1:0] m_axis_tdata,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [COORD_WIDTH-1:0]   i_cfg_data
);
    logic [COORD_WIDTH-1:0] r_left, r_top;
    logic [COORD_WIDTH-2:0] r_width, r_height;
    logic [4*COORD_WIDTH-1:0] r_out, seg;
    rlsc_pkg::t_cmd  cmd;
    rlsc_pkg::t_stat stat;
    logic capture;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0; r_top <= '0; r_width <= '0; r_height <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rlsc_pkg::REG_LEFT:   r_left   <= i_cfg_data;
                rlsc_pkg::REG_TOP:    r_top    <= i_cfg_data;
                rlsc_pkg::REG_WIDTH:  r_width  <= i_cfg_data[COORD_WIDTH-2:0];
                rlsc_pkg::REG_HEIGHT: r_height <= i_cfg_data[COORD_WIDTH-2:0];
                default: begin
                end
            endcase
        end
    end

    rlsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_capture   (capture)
    );

    rlsc_dp #(.CW(COORD_WIDTH)) u_dp (
        .i_clk    (i_clk),
        .i_left   (r_left),
        .i_top    (r_top),
        .i_width  (r_width),
        .i_height (r_height),
        .i_seg    (s_axis_tdata),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_seg    (seg)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (capture) r_out <= seg;
    end
    assign m_axis_tdata = r_out;

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for rect_line_segment_clipper
// drives segments and register writes, predicts clipped segments in place
// and checks every m_axis beat; uses rlsc_pkg and the clipper RTL

module tb_top;

    localparam int CW        = 16;
    localparam int LIMIT     = 3_000_000;
    localparam int DRAIN     = 800;
    localparam int N_RANDOM  = 730;

    // one segment, start_x in the lowest bits
    typedef struct packed {
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] sx;
    } t_seg;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [4*CW-1:0] s_axis_tdata = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [4*CW-1:0] m_axis_tdata;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [1:0]      i_cfg_index = rlsc_pkg::REG_LEFT;
    logic [CW-1:0]   i_cfg_data = '0;

    // predictor copy of the rectangle registers
    logic signed [CW-1:0] rect_left, rect_top;
    logic [CW-2:0]        rect_width, rect_height;
    longint               e_l, e_r, e_t, e_b;

    t_seg   clipped_q[$];
    int     n_sent, n_visible, n_checked, n_errors, n_cfg;
    longint cycles;
    bit     rx_no_stall;

    rect_line_segment_clipper #(.COORD_WIDTH(CW)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d segments still pending", cycles,
                     clipped_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic int region(longint x, longint y);
        int c;
        c = 0;
        if (x < e_l) c |= 1 << rlsc_pkg::OC_LEFT;
        if (x > e_r) c |= 1 << rlsc_pkg::OC_RIGHT;
        if (y < e_t) c |= 1 << rlsc_pkg::OC_TOP;
        if (y > e_b) c |= 1 << rlsc_pkg::OC_BOTTOM;
        return c;
    endfunction

    // trunc(b + n*o/d), exact
    function automatic longint slide(longint b, longint n, longint o, longint d);
        longint p, s;
        bit     neg;
        if (d == 0) return b;
        p = n * o;
        s = b + p / d;
        if (p % d != 0) begin
            neg = (p < 0) != (d < 0);
            if (s > 0 && neg) s = s - 1;
            else if (s < 0 && !neg) s = s + 1;
        end
        return s;
    endfunction

    // move an endpoint onto its first violated edge
    function automatic void snap(inout longint x, inout longint y, input longint dx,
                                 input longint dy);
        if (x < e_l) begin
            y = slide(y, dy, e_l - x, dx);
            x = e_l;
        end else if (x > e_r) begin
            y = slide(y, dy, e_r - x, dx);
            x = e_r;
        end else if (y < e_t) begin
            x = slide(x, dx, e_t - y, dy);
            y = e_t;
        end else if (y > e_b) begin
            x = slide(x, dx, e_b - y, dy);
            y = e_b;
        end
    endfunction

    function automatic bit clip_segment(input t_seg s, output t_seg r);
        longint x1, y1, x2, y2, dx, dy;
        int     c1, c2, rounds;
        x1 = longint'(s.sx);
        y1 = longint'(s.sy);
        x2 = longint'(s.ex);
        y2 = longint'(s.ey);
        r = '0;
        e_l = longint'(rect_left);
        e_t = longint'(rect_top);
        e_r = e_l + longint'(rect_width);
        e_b = e_t + longint'(rect_height);
        c1 = region(x1, y1);
        c2 = region(x2, y2);
        if ((c1 | c2) != 0) begin
            if ((c1 & c2) != 0) return 1'b0;
            if (y1 == y2) begin
                // horizontal, a single point lands here too
                if (x1 < x2) begin
                    if (x1 < e_l) x1 = e_l;
                    if (x2 > e_r) x2 = e_r;
                    if (x1 > x2) return 1'b0;
                end else begin
                    if (x2 < e_l) x2 = e_l;
                    if (x1 > e_r) x1 = e_r;
                    if (x1 < x2) return 1'b0;
                end
            end else if (x1 == x2) begin
                if (y1 < y2) begin
                    if (y1 < e_t) y1 = e_t;
                    if (y2 > e_b) y2 = e_b;
                    if (y1 > y2) return 1'b0;
                end else begin
                    if (y2 < e_t) y2 = e_t;
                    if (y1 > e_b) y1 = e_b;
                    if (y1 < y2) return 1'b0;
                end
            end else begin
                dx = x2 - x1;
                dy = y2 - y1;
                rounds = 0;
                while ((c1 | c2) != 0) begin
                    if (rounds >= rlsc_pkg::MAX_ROUNDS) return 1'b0;
                    rounds++;
                    if (c1 != 0) begin
                        snap(x1, y1, dx, dy);
                        c1 = region(x1, y1);
                        if ((c1 & c2) != 0) return 1'b0;
                    end
                    if (c2 != 0) begin
                        snap(x2, y2, dx, dy);
                        c2 = region(x2, y2);
                        if ((c1 & c2) != 0) return 1'b0;
                    end
                end
            end
        end
        r.sx = x1[CW-1:0];
        r.sy = y1[CW-1:0];
        r.ex = x2[CW-1:0];
        r.ey = y2[CW-1:0];
        return 1'b1;
    endfunction

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        t_seg got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            n_checked++;
            if (clipped_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected beat: sx=%0d sy=%0d ex=%0d ey=%0d",
                             got.sx, got.sy, got.ex, got.ey);
            end else begin
                want = clipped_q.pop_front();
                if (got.sx !== want.sx || got.sy !== want.sy ||
                    got.ex !== want.ex || got.ey !== want.ey) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp (%0d,%0d)-(%0d,%0d) got (%0d,%0d)-(%0d,%0d)",
                                 want.sx, want.sy, want.ex, want.ey,
                                 got.sx, got.sy, got.ex, got.ey);
                end
            end
        end
    end

    // receiver back-pressure: short stalls mostly, a few long ones
    always @(posedge i_clk) begin
        int run;
        if (run > 0) begin
            run--;
        end else if (rx_no_stall) begin
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(1, 0) == 1'b0) begin
            m_axis_tready <= 1'b0;
            run = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 0);
        end else begin
            m_axis_tready <= 1'b1;
            run = $urandom_range(8, 0);
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic int pick_gap();
        if ($urandom_range(2, 0) == 0) return 0;
        if ($urandom_range(9, 0) == 0) return $urandom_range(100, 20);
        return $urandom_range(4, 1);
    endfunction

    task automatic send_segment(input t_seg s, input int gap);
        t_seg r;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        if (clip_segment(s, r)) begin
            clipped_q = {clipped_q, r};
            n_visible++;
        end
    endtask

    task automatic seg(input int sx, input int sy, input int ex, input int ey);
        t_seg s;
        s.sx = sx[CW-1:0];
        s.sy = sy[CW-1:0];
        s.ex = ex[CW-1:0];
        s.ey = ey[CW-1:0];
        send_segment(s, pick_gap());
    endtask

    // drain the pipe, including segments that leave nothing
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (clipped_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            rlsc_pkg::REG_LEFT:   rect_left   = val;
            rlsc_pkg::REG_TOP:    rect_top    = val;
            rlsc_pkg::REG_WIDTH:  rect_width  = val[CW-2:0];
            rlsc_pkg::REG_HEIGHT: rect_height = val[CW-2:0];
            default: ;
        endcase
    endtask

    task automatic set_rect(input int l, input int t, input int w, input int h);
        wait_idle();
        write_reg(rlsc_pkg::REG_LEFT, l[CW-1:0]);
        write_reg(rlsc_pkg::REG_TOP, t[CW-1:0]);
        write_reg(rlsc_pkg::REG_WIDTH, w[CW-1:0]);
        write_reg(rlsc_pkg::REG_HEIGHT, h[CW-1:0]);
    endtask

    // coordinate near one axis range of the rectangle, or anywhere
    function automatic int near(longint lo, longint hi);
        longint span;
        span = hi - lo + 1;
        case ($urandom_range(5, 0))
            0:       return int'($urandom_range(65535, 0)) - 32768;
            1:       return int'(lo) - int'($urandom_range(3, 0));
            2:       return int'(hi) + int'($urandom_range(3, 0));
            default: return int'(lo - span + longint'($urandom_range(32'(3 * span), 0)));
        endcase
    endfunction

    task automatic random_segment();
        int sx, sy, ex, ey;
        longint l, t;
        l = longint'(rect_left);
        t = longint'(rect_top);
        sx = near(l, l + rect_width);
        sy = near(t, t + rect_height);
        ex = near(l, l + rect_width);
        ey = near(t, t + rect_height);
        case ($urandom_range(19, 0))
            0, 1: ey = sy;
            2, 3: ex = sx;
            4: begin
                ex = sx;
                ey = sy;
            end
            default: ;
        endcase
        seg(sx, sy, ex, ey);
    endtask

    // ---------------- tests ----------------

    // registers at reset: a one-pixel rectangle at the origin
    task automatic test_reset_rect();
        seg(0, 0, 0, 0);
        seg(1, 0, 1, 0);
        seg(-5, 0, 5, 0);
        seg(-3, -3, 3, 3);
    endtask

    task automatic test_trivial();
        set_rect(-10, -20, 40, 30);
        seg(0, 0, 5, 5);
        seg(-10, -20, 30, 10);
        seg(-50, -50, -20, 0);
        seg(40, 20, 60, -40);
        seg(0, 11, 20, 30);
    endtask

    // horizontal and vertical clamps both ways, and ones that lie wholly outside
    task automatic test_axis_aligned();
        seg(-100, 0, 100, 0);
        seg(100, 5, -100, 5);
        seg(3, -100, 3, 100);
        seg(3, 100, 3, -100);
        seg(-100, 10, -11, 10);
        seg(7, -30, 7, -21);
    endtask

    task automatic test_general();
        seg(-30, -30, 50, 30);
        seg(50, 25, -40, -35);
        seg(-15, 5, 10, -40);
        seg(-25, -25, 45, -19);
        seg(-20, 8, 28, 40);
    endtask

    // extreme coordinates and registers, oversized size writes
    task automatic test_extremes();
        set_rect(-32768, -32768, 16'hFFFF, 16'hFFFF);
        seg(-32768, -32768, 32767, 32767);
        seg(32767, -32768, -32768, 32767);
        set_rect(32767, 32767, 32767, 32767);
        seg(-32768, -32768, 32767, 32767);
        seg(32767, 32767, 32767, 32767);
        set_rect(100, -200, 0, 0);
        seg(100, -200, 100, -200);
        seg(-32768, -200, 32767, -200);
    endtask

    task automatic test_random();
        int per;
        per = N_RANDOM / 6;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_rect(-50, -50, 100, 100);
                1: set_rect(-32768, -32768, 32767, 32767);
                2: set_rect(32000, 32000, 32767, 32767);
                default: set_rect(int'($urandom_range(65535, 0)) - 32768,
                                  int'($urandom_range(65535, 0)) - 32768,
                                  ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
                                                              : $urandom_range(2000, 0),
                                  ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
                                                              : $urandom_range(2000, 0));
            endcase
            rx_no_stall = (ph == 3);
            for (int k = 0; k < per; k++) random_segment();
        end
        rx_no_stall = 1'b0;
    endtask

    initial begin
        n_sent = 0;
        n_visible = 0;
        n_checked = 0;
        n_errors = 0;
        n_cfg = 0;
        cycles = 0;
        rx_no_stall = 1'b0;
        rect_left = '0;
        rect_top = '0;
        rect_width = '0;
        rect_height = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_rect();
        test_trivial();
        test_axis_aligned();
        test_general();
        test_extremes();
        test_random();
        wait_idle();

        $display("%0d segments sent, %0d visible, %0d beats checked, %0d register writes",
                 n_sent, n_visible, n_checked, n_cfg);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0 && clipped_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
